// ----- hw/rtl/gsbr_pkg.sv -----
// Shared types, constants and helpers for the RGB border-renormalizing smoother.
`timescale 1ns / 1ps

package gsbr_pkg;

    localparam int MAX_RADIUS  = 3;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LINES       = 2 * MAX_RADIUS + 1;
    localparam int NUM_WEIGHTS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = 13;
    localparam int SLOT_W  = $clog2(LINES);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int KIDX_W  = 6;
    localparam int WIN_W   = 3;
    localparam int ACC_W   = 30;
    localparam int WSUM_W  = 22;
    localparam int QUO_W   = 8;

    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_DRAIN  = 2'd1;
    localparam logic [1:0] MODE_WEIGHT = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    // One beat travelling down the divider chain: three channel remainders
    // being reduced against a shared divisor, with their partial quotients.
    typedef struct packed {
        logic                          valid;
        logic [WSUM_W-1:0]             divisor;
        logic [2:0][ACC_W-1:0]         rem;
        logic [2:0][QUO_W-1:0]         quo;
        logic                          last;
        logic                          fend;
    } div_beat_t;

    // Reduces a slot sum in the range 0..20 to 0..6.
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [4:0] s);
        logic [4:0] t;
        begin
            t = s;
            if (t >= 5'd14)
            begin
                t = t - 5'd14;
            end
            else if (t >= 5'd7)
            begin
                t = t - 5'd7;
            end
            slot_wrap = t[SLOT_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/gsbr_div_cell.sv -----
// One cell of the divider chain: settles one quotient bit for all three channels.
`timescale 1ns / 1ps

module gsbr_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2:0]             bit_pos,
    input  gsbr_pkg::div_beat_t    beat_in,
    output gsbr_pkg::div_beat_t    beat_out
);

    gsbr_pkg::div_beat_t beat_next;
    gsbr_pkg::div_beat_t beat_reg;
    logic [gsbr_pkg::ACC_W-1:0] shifted;

    always_comb
    begin
        shifted = {{(gsbr_pkg::ACC_W - gsbr_pkg::WSUM_W){1'b0}}, beat_in.divisor} << bit_pos;
        beat_next = beat_in;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (beat_in.rem[ch] >= shifted)
            begin
                beat_next.rem[ch] = beat_in.rem[ch] - shifted;
                beat_next.quo[ch] = {beat_in.quo[ch][gsbr_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                beat_next.quo[ch] = {beat_in.quo[ch][gsbr_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

// ----- hw/rtl/rgb_gaussian_smooth_border_renorm.sv -----
// Top level of the streaming RGB smoother with border weight renormalization.
`timescale 1ns / 1ps

// Usage: items enter on the in channel (valid/ready). A mode 0 beat carries a
// pixel in raster order, mode 1 beats are drain ticks sent after a frame
// (radius times width of them), and mode 2 beats load one kernel weight.
// Smoothed pixels leave on the out channel (valid/ready), one beat each,
// R rows and R columns behind the input; at the end of each row the pending
// right-hand pixels of that output row follow, so one item yields up to four
// beats. last_of_run marks the final beat caused by an item and frame_end the
// bottom-right pixel of the frame.
// Timing: an item that yields no beat leaves the block ready for the next
// one. Each output pixel walks its (2R+1)^2 window through the single
// line-store read port, one tap per cycle, then passes ST_ACC to finish the
// sums and ST_LOAD to load the eight-cell divider chain, then runs through
// the chain into the output register. The next item is accepted once the
// last beat of the current one has been taken. Reset returns the position
// to row 0 column 0 and loads 640 x 480, radius 1; line store and weights
// are undefined until written. A stalled receiver holds the output beat and
// the block waits.
module rgb_gaussian_smooth_border_renorm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [5:0]  weight_index,
    input  logic [15:0] weight_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  blue_out,
    output logic [7:0]  green_out,
    output logic [7:0]  red_out,
    output logic        last_of_run,
    output logic        frame_end
);

    localparam int COL_W  = gsbr_pkg::COL_W;
    localparam int ROW_W  = gsbr_pkg::ROW_W;
    localparam int SLOT_W = gsbr_pkg::SLOT_W;
    localparam int ACC_W  = gsbr_pkg::ACC_W;
    localparam int WSUM_W = gsbr_pkg::WSUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_LOAD,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [11:0] fw_reg;
    logic [12:0] fh_reg;
    logic [1:0]  kr_reg;

    // Effective geometry.
    logic [11:0] w_eff;
    logic [12:0] h_eff;
    logic [2:0]  span;

    assign w_eff = (fw_reg == 12'd0) ? 12'd1 :
                   (fw_reg > 12'(gsbr_pkg::MAX_WIDTH)) ? 12'(gsbr_pkg::MAX_WIDTH) : fw_reg;
    assign h_eff = (fh_reg == 13'd0) ? 13'd1 :
                   (fh_reg > 13'(gsbr_pkg::MAX_HEIGHT)) ? 13'(gsbr_pkg::MAX_HEIGHT) : fh_reg;
    assign span  = {kr_reg, 1'b1};

    // Input position.
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Position after the out-of-range restart.
    logic              pos_bad;
    logic [COL_W-1:0]  col_e;
    logic [ROW_W-1:0]  row_e;
    logic [SLOT_W-1:0] slot_e;
    logic [13:0]       h_plus_r;

    assign h_plus_r = {1'b0, h_eff} + {12'd0, kr_reg};
    assign pos_bad  = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_plus_r);
    assign col_e    = pos_bad ? '0 : col_reg;
    assign row_e    = pos_bad ? '0 : row_reg;
    assign slot_e   = pos_bad ? '0 : slot_reg;

    // Position update and output range for a pixel or drain item.
    logic [11:0]       col_inc;
    logic [13:0]       row_inc;
    logic              col_last;
    logic              has_out;
    logic [COL_W-1:0]  w_m1;
    logic [COL_W-1:0]  start_col;
    logic [COL_W-1:0]  end_col;
    logic              col_ge_r;

    assign col_inc   = {1'b0, col_e} + 12'd1;
    assign row_inc   = {1'b0, row_e} + 14'd1;
    assign w_m1      = COL_W'(w_eff - 12'd1);
    assign col_last  = (col_e == w_m1);
    assign col_ge_r  = (col_e >= {{(COL_W-2){1'b0}}, kr_reg});
    assign has_out   = (row_e >= {{(ROW_W-2){1'b0}}, kr_reg}) && (col_ge_r || col_last);
    assign start_col = col_ge_r ? (col_e - {{(COL_W-2){1'b0}}, kr_reg}) : '0;
    assign end_col   = col_last ? w_m1 : (col_e - {{(COL_W-2){1'b0}}, kr_reg});

    logic in_acc;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Output walk state.
    logic [ROW_W-1:0]  orow_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic [COL_W-1:0]  olast_reg;
    logic [SLOT_W-1:0] wslot_reg;
    logic [2:0]        dy_reg;
    logic [2:0]        dx_reg;
    logic [5:0]        k_reg;

    // Window tap address and in-frame test.
    logic [11:0]       px_sum;
    logic [11:0]       px;
    logic [13:0]       py_sum;
    logic [13:0]       py;
    logic              tap_in;
    logic [SLOT_W-1:0] tap_slot;
    logic [gsbr_pkg::ADDR_W-1:0] rd_addr;

    assign px_sum   = {1'b0, ocol_reg} + {9'd0, dx_reg};
    assign px       = px_sum - {10'd0, kr_reg};
    assign py_sum   = {1'b0, orow_reg} + {11'd0, dy_reg};
    assign py       = py_sum - {12'd0, kr_reg};
    assign tap_in   = (px_sum >= {10'd0, kr_reg}) && (px < w_eff) &&
                      (py_sum >= {12'd0, kr_reg}) && (py < {1'b0, h_eff});
    assign tap_slot = gsbr_pkg::slot_wrap(5'({2'd0, wslot_reg}) + 5'd7 + {2'd0, dy_reg}
                                          - {2'd0, kr_reg, 1'b0});
    assign rd_addr  = {tap_slot, px[COL_W-1:0]};

    // Line store and weight memory.
    logic [23:0] line_mem [gsbr_pkg::LINES * gsbr_pkg::MAX_WIDTH];
    logic [15:0] wt_mem [gsbr_pkg::NUM_WEIGHTS];
    logic [23:0] pix_q_reg;
    logic [15:0] wt_q_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && (mode == gsbr_pkg::MODE_PIXEL || mode == gsbr_pkg::MODE_DRAIN)
            && (row_e < h_eff))
        begin
            line_mem[{slot_e, col_e}] <= {red, green, blue};
        end
        if (in_acc && mode == gsbr_pkg::MODE_WEIGHT
            && weight_index < 6'(gsbr_pkg::NUM_WEIGHTS))
        begin
            wt_mem[weight_index] <= weight_value;
        end
        pix_q_reg <= line_mem[rd_addr];
        wt_q_reg  <= wt_mem[k_reg];
    end

    // Accumulators.
    logic              rd_v_reg;
    logic [2:0][ACC_W-1:0] acc_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic              clear_acc;
    logic              tap_end;

    assign tap_end = (dx_reg == span - 3'd1) && (dy_reg == span - 3'd1);
    assign clear_acc = (in_acc && (mode == gsbr_pkg::MODE_PIXEL ||
                                   mode == gsbr_pkg::MODE_DRAIN) && has_out) ||
                       (state_reg == ST_OUT && out_ready && ocol_reg != olast_reg);

    always_ff @(posedge clk)
    begin
        if (clear_acc)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (rd_v_reg)
        begin
            wsum_reg <= wsum_reg + {6'd0, wt_q_reg};
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_reg[ch] <= acc_reg[ch] +
                               ACC_W'({16'd0, pix_q_reg[8*ch +: 8]} * {8'd0, wt_q_reg});
            end
        end
    end

    // Divider chain.
    gsbr_pkg::div_beat_t chain [9];

    always_comb
    begin
        chain[0].valid   = (state_reg == ST_LOAD);
        chain[0].divisor = wsum_reg;
        chain[0].rem     = acc_reg;
        chain[0].quo     = '0;
        chain[0].last    = (ocol_reg == olast_reg);
        chain[0].fend    = (orow_reg == h_eff - 13'd1) && (ocol_reg == w_m1);
    end

    for (genvar i = 0; i < 8; i++)
    begin : g_div
        gsbr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bit_pos  (3'(7 - i)),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    logic       out_valid_reg;
    logic [7:0] blue_reg;
    logic [7:0] green_reg;
    logic [7:0] red_reg;
    logic       last_reg;
    logic       fend_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && chain[8].valid)
        begin
            blue_reg  <= (chain[8].divisor == '0) ? 8'd0 : chain[8].quo[0];
            green_reg <= (chain[8].divisor == '0) ? 8'd0 : chain[8].quo[1];
            red_reg   <= (chain[8].divisor == '0) ? 8'd0 : chain[8].quo[2];
            last_reg  <= chain[8].last;
            fend_reg  <= chain[8].fend;
        end
    end

    // Sequencer, configuration and position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= 12'd640;
            fh_reg        <= 13'd480;
            kr_reg        <= 2'd1;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            olast_reg     <= '0;
            wslot_reg     <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (state_reg == ST_READ) && tap_in;
            if (cfg_write)
            begin
                case (cfg_index)
                    gsbr_pkg::CFG_WIDTH:  fw_reg <= cfg_data[11:0];
                    gsbr_pkg::CFG_HEIGHT: fh_reg <= cfg_data;
                    gsbr_pkg::CFG_RADIUS: kr_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (mode == gsbr_pkg::MODE_PIXEL ||
                                   mode == gsbr_pkg::MODE_DRAIN))
                    begin
                        if (col_inc >= w_eff)
                        begin
                            col_reg <= '0;
                            if (row_inc >= h_plus_r)
                            begin
                                row_reg  <= '0;
                                slot_reg <= '0;
                            end
                            else
                            begin
                                row_reg  <= row_inc[ROW_W-1:0];
                                slot_reg <= (slot_e == SLOT_W'(gsbr_pkg::LINES - 1)) ?
                                            '0 : slot_e + SLOT_W'(1);
                            end
                        end
                        else
                        begin
                            col_reg  <= col_inc[COL_W-1:0];
                            row_reg  <= row_e;
                            slot_reg <= slot_e;
                        end
                        if (has_out)
                        begin
                            orow_reg  <= row_e - {{(ROW_W-2){1'b0}}, kr_reg};
                            ocol_reg  <= start_col;
                            olast_reg <= end_col;
                            wslot_reg <= slot_e;
                            dy_reg    <= '0;
                            dx_reg    <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    k_reg <= k_reg + 6'd1;
                    if (dx_reg == span - 3'd1)
                    begin
                        dx_reg <= '0;
                        dy_reg <= dy_reg + 3'd1;
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 3'd1;
                    end
                    if (tap_end)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (chain[8].valid)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (ocol_reg == olast_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ocol_reg  <= ocol_reg + COL_W'(1);
                            dy_reg    <= '0;
                            dx_reg    <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign blue_out    = blue_reg;
    assign green_out   = green_reg;
    assign red_out     = red_reg;
    assign last_of_run = last_reg;
    assign frame_end   = fend_reg;

endmodule
